>>> rtl/core/rmd_pkg.sv
// Shared types, constants and round functions of the RIPEMD-160 hash core.
`timescale 1ns / 1ps
`default_nettype none

package rmd_pkg;

  // Input item and result item
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        first_of_message;
    logic        last_of_message;
  } rmd_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        last_digest;
  } rmd_out_t;

  // Five 32-bit words: chaining value or one working line
  typedef logic [4:0][31:0] rmd_cv_t;

  // Control from the sequencer to the compression engine
  typedef struct packed {
    logic start;
    logic cv_init;
  } rmd_ctl_t;

  localparam int unsigned NumRounds  = 80;
  localparam int unsigned BlockWords = 16;

  localparam logic [3:0]  LastPos    = 4'd15;
  localparam logic [3:0]  LenLoPos   = 4'd14;
  localparam logic [2:0]  FullBytes  = 3'd4;
  localparam logic [2:0]  LastDigIdx = 3'd4;
  localparam logic [31:0] MarkerWord = 32'h0000_0080;

  localparam rmd_cv_t InitCv = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                32'hefcdab89, 32'h67452301};

  localparam logic [3:0] SelL [NumRounds] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
    4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
    4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
    4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
    4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
    4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
    4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13};

  localparam logic [3:0] SelR [NumRounds] = '{
    4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
    4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
    4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
    4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
    4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
    4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
    4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
    4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
    4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
    4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11};

  localparam logic [3:0] RotL [NumRounds] = '{
    4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
    4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
    4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
    4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
    4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
    4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
    4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
    4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
    4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
    4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6};

  localparam logic [3:0] RotR [NumRounds] = '{
    4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
    4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
    4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
    4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
    4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
    4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
    4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
    4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
    4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
    4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11};

  localparam logic [31:0] AddL [5] = '{
    32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E};
  localparam logic [31:0] AddR [5] = '{
    32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000};

  // Rotate left by 0..15
  function automatic logic [31:0] rotl(logic [31:0] x, logic [3:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

  // Boolean function of one round group
  function automatic logic [31:0] mix(logic [2:0] g, logic [31:0] x,
                                      logic [31:0] y, logic [31:0] z);
    logic [31:0] r;
    case (g)
      3'd0:    r = x ^ y ^ z;
      3'd1:    r = (x & y) | (~x & z);
      3'd2:    r = (x | ~y) ^ z;
      3'd3:    r = (x & z) | (y & ~z);
      default: r = x ^ (y | ~z);
    endcase
    return r;
  endfunction

  // One step of one line: v is {e, d, c, b, a} with a in word 0
  function automatic rmd_cv_t line_step(rmd_cv_t v, logic [2:0] g, logic [31:0] w,
                                        logic [31:0] k, logic [3:0] s);
    logic [31:0] sum;
    rmd_cv_t     n;
    sum  = v[0] + mix(g, v[1], v[2], v[3]) + w + k;
    n[0] = v[4];
    n[4] = v[3];
    n[3] = rotl(v[2], 4'd10);
    n[2] = v[1];
    n[1] = rotl(sum, s) + v[4];
    return n;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rmd_msg_mem.sv
// Message block memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module rmd_msg_mem (
  input  wire logic        clk_i,
  input  wire logic        wr_en_i,
  input  wire logic [3:0]  wr_addr_i,
  input  wire logic [31:0] wr_data_i,
  input  wire logic [3:0]  rd_addr_a_i,
  input  wire logic [3:0]  rd_addr_b_i,
  output logic      [31:0] rd_data_a_o,
  output logic      [31:0] rd_data_b_o
);

  logic [31:0] mem_q [rmd_pkg::BlockWords];
  logic [31:0] rd_data_a_q;
  logic [31:0] rd_data_b_q;

  // Write the addressed word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read both ports into registers
  always_ff @(posedge clk_i) begin
    rd_data_a_q <= mem_q[rd_addr_a_i];
    rd_data_b_q <= mem_q[rd_addr_b_i];
  end

  assign rd_data_a_o = rd_data_a_q;
  assign rd_data_b_o = rd_data_b_q;

endmodule

`default_nettype wire

>>> rtl/core/rmd_compress.sv
// Compression engine: chaining value, both working lines, one round a cycle.
`timescale 1ns / 1ps
`default_nettype none

module rmd_compress (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rmd_pkg::rmd_ctl_t ctl_i,
  output logic       [3:0]       rd_addr_l_o,
  output logic       [3:0]       rd_addr_r_o,
  input  wire logic  [31:0]      rd_data_l_i,
  input  wire logic  [31:0]      rd_data_r_i,
  output rmd_pkg::rmd_cv_t       cv_o,
  output logic                   done_o
);

  typedef enum logic [1:0] {C_IDLE, C_LOAD, C_ROUND, C_FINAL} cstate_e;

  localparam logic [6:0] FinalRound = 7'(rmd_pkg::NumRounds - 1);

  cstate_e          state_q;
  logic [6:0]       round_q;
  logic [6:0]       nxt_round;
  logic [6:0]       rd_idx;
  logic [2:0]       grp_l;
  logic [2:0]       grp_r;
  rmd_pkg::rmd_cv_t cv_q;
  rmd_pkg::rmd_cv_t cv_d;
  rmd_pkg::rmd_cv_t left_q;
  rmd_pkg::rmd_cv_t right_q;
  rmd_pkg::rmd_cv_t left_d;
  rmd_pkg::rmd_cv_t right_d;

  // Address the words of the next round ahead of it, through the registered read
  always_comb begin
    nxt_round   = (round_q == FinalRound) ? round_q : 7'(round_q + 7'd1);
    rd_idx      = (state_q == C_ROUND) ? nxt_round : '0;
    rd_addr_l_o = rmd_pkg::SelL[rd_idx];
    rd_addr_r_o = rmd_pkg::SelR[rd_idx];
  end

  // Step both lines
  always_comb begin
    grp_l   = round_q[6:4];
    grp_r   = 3'(3'd4 - grp_l);
    left_d  = rmd_pkg::line_step(left_q, grp_l, rd_data_l_i, rmd_pkg::AddL[grp_l],
                                 rmd_pkg::RotL[round_q]);
    right_d = rmd_pkg::line_step(right_q, grp_r, rd_data_r_i, rmd_pkg::AddL[0] |
                                 rmd_pkg::AddR[grp_l], rmd_pkg::RotR[round_q]);
  end

  // Fold both lines into the chaining value
  always_comb begin
    cv_d[0] = cv_q[1] + left_q[2] + right_q[3];
    cv_d[1] = cv_q[2] + left_q[3] + right_q[4];
    cv_d[2] = cv_q[3] + left_q[4] + right_q[0];
    cv_d[3] = cv_q[4] + left_q[0] + right_q[1];
    cv_d[4] = cv_q[0] + left_q[1] + right_q[2];
  end

  // Sequence chaining value init, load, 80 rounds and the final fold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      round_q <= '0;
      cv_q    <= rmd_pkg::InitCv;
      left_q  <= '0;
      right_q <= '0;
    end else begin
      case (state_q)
        C_IDLE: begin
          if (ctl_i.cv_init) begin
            cv_q <= rmd_pkg::InitCv;
          end
          if (ctl_i.start) begin
            state_q <= C_LOAD;
          end
        end
        C_LOAD: begin
          left_q  <= cv_q;
          right_q <= cv_q;
          round_q <= '0;
          state_q <= C_ROUND;
        end
        C_ROUND: begin
          left_q  <= left_d;
          right_q <= right_d;
          if (round_q == FinalRound) begin
            state_q <= C_FINAL;
          end else begin
            round_q <= nxt_round;
          end
        end
        C_FINAL: begin
          cv_q    <= cv_d;
          round_q <= '0;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign cv_o   = cv_q;
  assign done_o = (state_q == C_FINAL);

endmodule

`default_nettype wire

>>> rtl/core/ripemd160_hash_core.sv
// Top level of the streaming RIPEMD-160 hash core.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one 32-bit
//   message word per transfer, first byte in bits 7:0. first_of_message
//   restarts the hash; last_of_message closes it, with byte_count (0..4,
//   larger values count as 4) valid low bytes in that word.
//   Output channel (out_valid_o / out_ready_i / out_data_o) carries the five
//   digest words, index 0 first, last_digest set on index 4.
//   A word that does not fill a block leaves the input ready. The sixteenth
//   word of a block starts the compression engine, which runs one round of
//   both lines per cycle (load, 80 rounds, fold); input waits until it is
//   done. On a last word the padding words are written one per cycle unless
//   a block is compressing, one or two blocks are compressed, and the digest
//   is then offered, one word per cycle while the receiver takes them.
//   The input stays not ready from a last word until the fifth digest word
//   is transferred; a stalled receiver holds the block in that state.
//   Reset loads the standard initial chaining value, clears the bit length
//   and word position; the message memory is not cleared and needs no pass.
`timescale 1ns / 1ps
`default_nettype none

module ripemd160_hash_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rmd_pkg::rmd_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rmd_pkg::rmd_out_t      out_data_o
);

  typedef enum logic [2:0] {ST_IDLE, ST_MARK, ST_FILL, ST_COMP, ST_OUT} state_e;

  state_e           state_q;
  state_e           ret_q;
  state_e           after_wr;
  logic [3:0]       pos_q;
  logic [63:0]      len_q;
  logic [63:0]      len_d;
  logic             lo_done_q;
  logic [2:0]       out_idx_q;
  logic             in_fire;
  logic [3:0]       pos_eff;
  logic [2:0]       cnt_sat;
  logic [31:0]      last_word;
  logic             wr_en;
  logic [3:0]       wr_addr;
  logic [31:0]      wr_data;
  logic             blk_full;
  logic [3:0]       rd_addr_l;
  logic [3:0]       rd_addr_r;
  logic [31:0]      rd_data_l;
  logic [31:0]      rd_data_r;
  logic             comp_done;
  rmd_pkg::rmd_ctl_t ctl;
  rmd_pkg::rmd_cv_t  cv;

  // Decode the input item
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    in_fire    = in_valid_i && in_ready_o;
    pos_eff    = in_data_i.first_of_message ? '0 : pos_q;
    cnt_sat    = (in_data_i.byte_count > rmd_pkg::FullBytes) ? rmd_pkg::FullBytes
                                                             : in_data_i.byte_count;
    case (cnt_sat)
      3'd0:    last_word = rmd_pkg::MarkerWord;
      3'd1:    last_word = {16'h0000, 8'h80, in_data_i.data_word[7:0]};
      3'd2:    last_word = {8'h00, 8'h80, in_data_i.data_word[15:0]};
      3'd3:    last_word = {8'h80, in_data_i.data_word[23:0]};
      default: last_word = in_data_i.data_word;
    endcase
    len_d = (in_data_i.first_of_message ? 64'd0 : len_q) +
            (in_data_i.last_of_message ? {58'd0, cnt_sat, 3'b000} : 64'd32);
  end

  // Select the word written into the block
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = pos_q;
    wr_data  = '0;
    after_wr = ST_IDLE;
    case (state_q)
      ST_IDLE: begin
        wr_en   = in_fire;
        wr_addr = pos_eff;
        wr_data = in_data_i.last_of_message ? last_word : in_data_i.data_word;
        if (in_data_i.last_of_message) begin
          after_wr = (cnt_sat == rmd_pkg::FullBytes) ? ST_MARK : ST_FILL;
        end
      end
      ST_MARK: begin
        wr_en    = 1'b1;
        wr_data  = rmd_pkg::MarkerWord;
        after_wr = ST_FILL;
      end
      ST_FILL: begin
        wr_en = 1'b1;
        if (pos_q == rmd_pkg::LenLoPos) begin
          wr_data = len_q[31:0];
        end else if (pos_q == rmd_pkg::LastPos && lo_done_q) begin
          wr_data = len_q[63:32];
        end
        after_wr = lo_done_q ? ST_OUT : ST_FILL;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    blk_full    = wr_en && (wr_addr == rmd_pkg::LastPos);
    ctl.start   = blk_full;
    ctl.cv_init = in_fire && in_data_i.first_of_message;
  end

  // Advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= ST_IDLE;
      pos_q     <= '0;
      len_q     <= '0;
      lo_done_q <= 1'b0;
      out_idx_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            len_q     <= len_d;
            pos_q     <= 4'(pos_eff + 4'd1);
            lo_done_q <= 1'b0;
            if (blk_full) begin
              ret_q   <= after_wr;
              state_q <= ST_COMP;
            end else begin
              state_q <= after_wr;
            end
          end
        end
        ST_MARK, ST_FILL: begin
          pos_q <= 4'(pos_q + 4'd1);
          if (state_q == ST_FILL && pos_q == rmd_pkg::LenLoPos) begin
            lo_done_q <= 1'b1;
          end
          if (blk_full) begin
            ret_q   <= after_wr;
            state_q <= ST_COMP;
          end else begin
            state_q <= after_wr;
          end
        end
        ST_COMP: begin
          if (comp_done) begin
            state_q <= ret_q;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            if (out_idx_q == rmd_pkg::LastDigIdx) begin
              out_idx_q <= '0;
              state_q   <= ST_IDLE;
            end else begin
              out_idx_q <= 3'(out_idx_q + 3'd1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Drive the digest from the held chaining value
  always_comb begin
    out_valid_o             = (state_q == ST_OUT);
    out_data_o.digest_word  = cv[out_idx_q];
    out_data_o.digest_index = out_idx_q;
    out_data_o.last_digest  = (out_idx_q == rmd_pkg::LastDigIdx);
  end

  rmd_msg_mem u_msg_mem (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_addr_a_i (rd_addr_l),
    .rd_addr_b_i (rd_addr_r),
    .rd_data_a_o (rd_data_l),
    .rd_data_b_o (rd_data_r)
  );

  rmd_compress u_compress (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .rd_addr_l_o (rd_addr_l),
    .rd_addr_r_o (rd_addr_r),
    .rd_data_l_i (rd_data_l),
    .rd_data_r_i (rd_data_r),
    .cv_o        (cv),
    .done_o      (comp_done)
  );

endmodule

`default_nettype wire

>>> rtl/core/rmd_checker.sv
// Port-level checker of the RIPEMD-160 hash core and its bind.
`timescale 1ns / 1ps
`default_nettype none

module rmd_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire rmd_pkg::rmd_in_t  in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire rmd_pkg::rmd_out_t out_data_o
);

  // No digest is offered once reset has been seen at an edge
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("digest offered during reset");

  // Input is closed while a digest is offered
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !(in_ready_o && out_valid_o))
    else $error("input ready while digest pending");

  // Final flag marks index four
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (out_data_o.last_digest == (out_data_o.digest_index == 3'd4)))
    else $error("last_digest does not match digest_index");

  // Digest words follow in index order
  a_next_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_ready_i && !out_data_o.last_digest) |=>
      (out_valid_o && out_data_o.digest_index == 3'($past(out_data_o.digest_index) + 3'd1)))
    else $error("digest word missing or out of order");

  // Output drops after the final word transfer
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_ready_i && out_data_o.last_digest) |=> !out_valid_o)
    else $error("extra digest word after the last");

endmodule

bind ripemd160_hash_core rmd_checker u_rmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
